### hdl/qss_pkg.sv
package qss_pkg;

   localparam int SIZE        = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_W       = $clog2(SIZE);
   localparam int STACK_DEPTH = SIZE / 2;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = STK_AW + 1;
   localparam int COUNT_W     = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(SIZE);

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_STEP = 2'd1,
      MODE_READ = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ELEMENT_COUNT = 2'd0,
      REG_STARTED       = 2'd1,
      REG_PAUSED        = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } range_type;

endpackage

### hdl/qss_ram.sv
module qss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/quick_sort_stepper.sv
// Channel   Ports                                  Transfer
// -------   -------------------------------------  -------------------------------
// request   start, busy, req_mode/index/value      start high while busy is low
// response  rsp_valid, rsp_*                       one cycle strobe, no backpressure
// config    csr_valid, csr_ready, csr_index/wdata  valid and ready both high
//
// A load, an unused mode or an idle step is answered straight from idle; a read waits in
// S_READ for the registered memory output.
// A sort step scans its range once and spends extra states on each swap; the first step of a
// sort skips the stack pop. A swap is an exchange of two different positions, the final
// pivot move included: the element memory has one read and one write port, and each swap
// needs two writes.
// Reset clears control state only; both memories hold garbage until written.
// The response cannot be stalled; a new request may be taken while the strobe is high.
module quick_sort_stepper
   import qss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_mode,
   input  logic [IDX_W-1:0]        req_index,
   input  logic [DATA_WIDTH-1:0]   req_value,
   output logic                    rsp_valid,
   output logic [DATA_WIDTH-1:0]   rsp_read_value,
   output logic [IDX_W-1:0]        rsp_range_low,
   output logic [IDX_W-1:0]        rsp_range_high,
   output logic [IDX_W-1:0]        rsp_pivot_position,
   output logic                    rsp_pivot_valid,
   output logic                    rsp_done_res,
   output logic [COUNT_W-1:0]      rsp_step_count,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_POP, S_PCAP, S_JCMP, S_SWAPA, S_SWAPB,
      S_FIN, S_FINA, S_FINB, S_PUSHL, S_PUSHR
   } state_type;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]      lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in, store_ff, store_in;
   logic [DATA_WIDTH-1:0] pivot_ff, pivot_in, aj_ff, aj_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic                  begun_ff, begun_in, done_ff, done_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    elem_count_ff, elem_count_in;
   logic                  started_ff, started_in, paused_ff, paused_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [IDX_W-1:0]      rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;
   logic [IDX_W-1:0]      rsp_pivot_ff, rsp_pivot_in;
   logic                  rsp_pvalid_ff, rsp_pvalid_in, rsp_done_ff, rsp_done_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  elem_we;
   logic [IDX_W-1:0]      elem_waddr, elem_raddr;
   logic [DATA_WIDTH-1:0] elem_wdata, elem_rdata;
   logic                  stk_we;
   logic [STK_AW-1:0]     stk_waddr, stk_raddr;
   range_type             stk_wdata, stk_rdata;

   logic                  accept;
   logic [IDX_W-1:0]      last_index;
   logic                  is_less;
   logic [IDX_W-1:0]      j_next;
   logic                  stack_room;

   qss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SIZE)) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (elem_waddr),
      .wdata (elem_wdata),
      .raddr (elem_raddr),
      .rdata (elem_rdata)
   );

   qss_ram #(.WIDTH($bits(range_type)), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   // Element count of zero acts as one, anything above the array size as the full array.
   assign last_index = (elem_count_ff == '0) ? '0 :
                       (elem_count_ff > COUNT_W'(SIZE)) ? IDX_W'(SIZE - 1) :
                       IDX_W'(elem_count_ff - 1'b1);

   assign is_less    = $signed(elem_rdata) < $signed(pivot_ff);
   assign j_next     = j_ff + 1'b1;
   assign stack_room = (depth_ff < DEPTH_W'(STACK_DEPTH));

   always_comb begin
      state_in          = state_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      j_in              = j_ff;
      store_in          = store_ff;
      pivot_in          = pivot_ff;
      aj_in             = aj_ff;
      depth_in          = depth_ff;
      begun_in          = begun_ff;
      done_in           = done_ff;
      count_in          = count_ff;
      elem_count_in     = elem_count_ff;
      started_in        = started_ff;
      paused_in         = paused_ff;
      rsp_valid_in      = 1'b0;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_lo_in         = rsp_lo_ff;
      rsp_hi_in         = rsp_hi_ff;
      rsp_pivot_in      = rsp_pivot_ff;
      rsp_pvalid_in     = rsp_pvalid_ff;
      rsp_done_in       = rsp_done_ff;
      rsp_count_in      = rsp_count_ff;
      elem_we           = 1'b0;
      elem_waddr        = j_ff;
      elem_wdata        = elem_rdata;
      elem_raddr        = j_next;
      stk_we            = 1'b0;
      stk_waddr         = depth_ff[STK_AW-1:0];
      stk_wdata         = '{lo: lo_ff, hi: IDX_W'(store_ff - 1'b1)};
      stk_raddr         = STK_AW'(depth_ff - 1'b1);

      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_ELEMENT_COUNT: elem_count_in = csr_wdata;
            REG_STARTED:       started_in    = csr_wdata[0];
            REG_PAUSED:        paused_in     = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            elem_raddr        = (req_mode == MODE_READ) ? req_index : last_index;
            rsp_read_value_in = '0;
            rsp_lo_in         = '0;
            rsp_hi_in         = '0;
            rsp_pivot_in      = '0;
            rsp_pvalid_in     = 1'b0;
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_LOAD: begin
                     elem_we      = 1'b1;
                     elem_waddr   = req_index;
                     elem_wdata   = req_value;
                     depth_in     = '0;
                     begun_in     = 1'b0;
                     done_in      = 1'b0;
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_done_in  = 1'b0;
                     rsp_count_in = '0;
                  end
                  MODE_READ: begin
                     state_in = S_READ;
                  end
                  MODE_STEP: begin
                     if (done_ff || !started_ff || paused_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_done_in  = done_ff;
                        rsp_count_in = count_ff;
                     end else if (!begun_ff) begin
                        // The whole range is pushed and popped at once; the pivot read
                        // is already on its way.
                        begun_in = 1'b1;
                        lo_in    = '0;
                        hi_in    = last_index;
                        state_in = S_PCAP;
                     end else if (depth_ff == '0) begin
                        done_in      = 1'b1;
                        begun_in     = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_done_in  = 1'b1;
                        rsp_count_in = count_ff;
                     end else begin
                        depth_in = depth_ff - 1'b1;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_done_in  = done_ff;
                     rsp_count_in = count_ff;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_read_value_in = elem_rdata;
            rsp_done_in       = done_ff;
            rsp_count_in      = count_ff;
            state_in          = S_IDLE;
         end
         S_POP: begin
            lo_in      = stk_rdata.lo;
            hi_in      = stk_rdata.hi;
            elem_raddr = stk_rdata.hi;
            state_in   = S_PCAP;
         end
         S_PCAP: begin
            pivot_in   = elem_rdata;
            j_in       = lo_ff;
            store_in   = lo_ff;
            elem_raddr = lo_ff;
            state_in   = (lo_ff == hi_ff) ? S_FIN : S_JCMP;
         end
         S_JCMP: begin
            if (is_less && (store_ff != j_ff)) begin
               aj_in      = elem_rdata;
               elem_raddr = store_ff;
               state_in   = S_SWAPA;
            end else begin
               if (is_less) begin
                  store_in = store_ff + 1'b1;
               end
               j_in     = j_next;
               state_in = (j_next == hi_ff) ? S_FIN : S_JCMP;
            end
         end
         S_SWAPA: begin
            // Element at the store position moves up to the scan position.
            elem_we    = 1'b1;
            elem_waddr = j_ff;
            elem_wdata = elem_rdata;
            state_in   = S_SWAPB;
         end
         S_SWAPB: begin
            elem_we    = 1'b1;
            elem_waddr = store_ff;
            elem_wdata = aj_ff;
            store_in   = store_ff + 1'b1;
            j_in       = j_next;
            state_in   = (j_next == hi_ff) ? S_FIN : S_JCMP;
         end
         S_FIN: begin
            elem_raddr = store_ff;
            state_in   = (store_ff == hi_ff) ? S_PUSHL : S_FINA;
         end
         S_FINA: begin
            elem_we    = 1'b1;
            elem_waddr = hi_ff;
            elem_wdata = elem_rdata;
            state_in   = S_FINB;
         end
         S_FINB: begin
            elem_we    = 1'b1;
            elem_waddr = store_ff;
            elem_wdata = pivot_ff;
            state_in   = S_PUSHL;
         end
         S_PUSHL: begin
            if (({1'b0, store_ff} >= {1'b0, lo_ff} + (IDX_W+1)'(2)) && stack_room) begin
               stk_we   = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
            state_in = S_PUSHR;
         end
         S_PUSHR: begin
            stk_wdata = '{lo: IDX_W'(store_ff + 1'b1), hi: hi_ff};
            if (({1'b0, store_ff} + (IDX_W+1)'(2) <= {1'b0, hi_ff}) && stack_room) begin
               stk_we   = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            rsp_valid_in      = 1'b1;
            rsp_read_value_in = '0;
            rsp_lo_in         = lo_ff;
            rsp_hi_in         = hi_ff;
            rsp_pivot_in      = store_ff;
            rsp_pvalid_in     = 1'b1;
            rsp_done_in       = done_ff;
            rsp_count_in      = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         depth_ff      <= '0;
         begun_ff      <= 1'b0;
         done_ff       <= 1'b0;
         count_ff      <= '0;
         elem_count_ff <= COUNT_RESET;
         started_ff    <= 1'b0;
         paused_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         begun_ff      <= begun_in;
         done_ff       <= done_in;
         count_ff      <= count_in;
         elem_count_ff <= elem_count_in;
         started_ff    <= started_in;
         paused_ff     <= paused_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lo_ff             <= lo_in;
      hi_ff             <= hi_in;
      j_ff              <= j_in;
      store_ff          <= store_in;
      pivot_ff          <= pivot_in;
      aj_ff             <= aj_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_lo_ff         <= rsp_lo_in;
      rsp_hi_ff         <= rsp_hi_in;
      rsp_pivot_ff      <= rsp_pivot_in;
      rsp_pvalid_ff     <= rsp_pvalid_in;
      rsp_done_ff       <= rsp_done_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_range_low      = rsp_lo_ff;
   assign rsp_range_high     = rsp_hi_ff;
   assign rsp_pivot_position = rsp_pivot_ff;
   assign rsp_pivot_valid    = rsp_pvalid_ff;
   assign rsp_done_res       = rsp_done_ff;
   assign rsp_step_count     = rsp_count_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("range stack depth beyond capacity");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while a request is still in progress");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JCMP || state_ff == S_SWAPA || state_ff == S_SWAPB)
      |-> (store_ff <= j_ff && j_ff < hi_ff && lo_ff <= store_ff))
      else $error("partition indices out of order");

   a_pivot_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pivot_valid)
      |-> (rsp_range_low <= rsp_pivot_position && rsp_pivot_position <= rsp_range_high))
      else $error("pivot position outside its range");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_LOAD)
      |=> (rsp_valid && rsp_step_count == '0 && !rsp_done_res))
      else $error("load transfer did not clear sort progress");

endmodule
